FILE: src/afma_pkg.sv
package afma_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 16;
  localparam int BYTE_W         = 8;
  localparam int CFG_W          = 7;
  localparam int FRAC_W         = 16;
  localparam int Q_W            = 24;
  localparam int AVG_W          = 25;
  localparam int SCALE_SHIFT    = Q_W - FRAC_W;
  localparam int DIV_STEPS      = Q_W;
  localparam int AXES           = 3;
  localparam int AXIS_W         = 2;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LEN = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] z;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic clear;
    logic we;
    logic re;
  } store_ctl_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

endpackage

FILE: src/afma_sample_store.sv
module afma_sample_store #(
  parameter int WINDOW_MAX = afma_pkg::WINDOW_MAX_DEF,
  parameter int AW         = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afma_pkg::store_ctl_t ctl_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [AW-1:0]        raddr_i,
  input  afma_pkg::sample_t    wdata_i,
  output afma_pkg::sample_t    rdata_o
);

  afma_pkg::sample_t       mem [WINDOW_MAX];
  afma_pkg::sample_t       rd_q;
  logic [WINDOW_MAX-1:0]   vld_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rd_q <= mem[raddr_i];
    end
  end

  // rows never written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        vld_q <= '0;
      end else if (ctl_i.we) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/afma_divider.sv
module afma_divider #(
  parameter int DVS_W = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  afma_pkg::div_ctl_t                   ctl_i,
  input  logic [DVS_W+afma_pkg::SCALE_SHIFT-1:0] mag_i,
  input  logic [DVS_W-1:0]                     dvs_i,
  output logic                                 done_o,
  output logic signed [afma_pkg::AVG_W-1:0]    quot_o
);

  localparam int MAG_W = DVS_W + afma_pkg::SCALE_SHIFT;
  localparam int CNT_W = $clog2(afma_pkg::DIV_STEPS + 1);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DVS_W-1:0]         rem_q;
  logic [DVS_W-1:0]         rem_d;
  logic [afma_pkg::Q_W-1:0] dq_q;
  logic                     neg_q;
  logic [DVS_W:0]           trial;
  logic                     ge;
  logic [afma_pkg::AVG_W-1:0] q_ext;

  // restoring division, one quotient bit per cycle; quotient shifts in at the low end
  assign trial = {rem_q, dq_q[afma_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_i};
  always_comb begin
    rem_d = trial[DVS_W-1:0];
    if (ge) begin
      rem_d = DVS_W'(trial - {1'b0, dvs_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(afma_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= mag_i[MAG_W-1:afma_pkg::SCALE_SHIFT];
      dq_q  <= {mag_i[afma_pkg::SCALE_SHIFT-1:0], {afma_pkg::FRAC_W{1'b0}}};
      neg_q <= ctl_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[afma_pkg::Q_W-2:0], ge};
    end
  end

  assign q_ext  = {1'b0, dq_q};
  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(-q_ext) : $signed(q_ext);

endmodule

FILE: src/accel_frame_moving_average.sv
// Three-axis boxcar moving average of accelerometer frames.
// Input channel (in_valid_i/in_ready_o): one beat is a seven-byte frame, the
// device id and x, y, z as little-endian 16-bit two's complement samples.
// Output channel (out_valid_o/out_ready_i): one beat per frame with the
// device id and the three window averages in signed Q8.16 g, truncated
// toward zero.
// APB port: register 0 (address 0) is window_length, 1..WINDOW_MAX; only
// pwdata[6:0] is used, 0 is taken as 1 and larger values as WINDOW_MAX.
// A write clears the sample store. After the frame beat, the sum pass reads
// the sample memory once per slot, then one shared restoring divider runs
// each axis in turn, and ST_DONE loads the output register once it is free.
// in_ready_o is high only while idle, so one frame is in flight at a time and
// no new frame is taken until the last one is loaded into the output register.
// Reset clears the sample store, the write position and sets window_length to
// 1. A stalled receiver holds the result in the output register; the next
// frame is still taken and computed, and waits for that register to free up.
module accel_frame_moving_average #(
  parameter int WINDOW_MAX = afma_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [afma_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [afma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [afma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          device_id_byte_i,
  input  logic [7:0]                          x_low_byte_i,
  input  logic [7:0]                          x_high_byte_i,
  input  logic [7:0]                          y_low_byte_i,
  input  logic [7:0]                          y_high_byte_i,
  input  logic [7:0]                          z_low_byte_i,
  input  logic [7:0]                          z_high_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          device_id_o,
  output logic signed [afma_pkg::AVG_W-1:0]   x_average_o,
  output logic signed [afma_pkg::AVG_W-1:0]   y_average_o,
  output logic signed [afma_pkg::AVG_W-1:0]   z_average_o
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int DVS_W = LEN_W + afma_pkg::BYTE_W;
  localparam int SUM_W = LEN_W + afma_pkg::SAMPLE_W;

  afma_pkg::state_e state_q, state_d;
  logic [LEN_W-1:0]            len_q, len_d;
  logic [LEN_W-1:0]            pos_q, pos_d;
  logic [LEN_W-1:0]            cnt_q, cnt_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [afma_pkg::AXIS_W-1:0] axis_q, axis_d;
  logic                        div_run_q, div_run_d;
  logic                        out_valid_q, out_valid_d;

  logic [7:0]                        id_q;
  logic signed [SUM_W-1:0]           sum_q [afma_pkg::AXES];
  logic signed [afma_pkg::AVG_W-1:0] res_q [afma_pkg::AXES];

  logic                            cfg_we;
  logic                            cfg_hit;
  logic [afma_pkg::CFG_W-1:0]      cfg_val;
  logic                            accept;
  logic                            rd_en;
  logic                            load_out;
  logic [LEN_W:0]                  pos_inc;
  logic [LEN_W-1:0]                pos_new;
  logic [LEN_W-1:0]                slot;
  afma_pkg::store_ctl_t            st_ctl;
  afma_pkg::sample_t               wdata;
  afma_pkg::sample_t               rdata;
  afma_pkg::div_ctl_t              div_ctl;
  logic                            div_done;
  logic signed [afma_pkg::AVG_W-1:0] quot;
  logic signed [SUM_W-1:0]         sum_sel;
  logic [SUM_W-1:0]                mag;
  logic [DVS_W-1:0]                dvs;

  // APB
  assign pready  = 1'b1;
  assign cfg_hit = paddr[afma_pkg::APB_ADDR_W-1:2] == afma_pkg::REG_WINDOW_LEN;
  assign cfg_we  = psel & penable & pwrite & cfg_hit;
  assign cfg_val = pwdata[afma_pkg::CFG_W-1:0];
  assign prdata  = cfg_hit ? afma_pkg::APB_DATA_W'(len_q) : '0;

  always_comb begin
    len_d = len_q;
    if (cfg_we) begin
      if (cfg_val == '0) begin
        len_d = LEN_W'(1);
      end else if (32'(cfg_val) > WINDOW_MAX) begin
        len_d = LEN_W'(WINDOW_MAX);
      end else begin
        len_d = LEN_W'(cfg_val);
      end
    end
  end

  // write position wraps to 1 past the window
  assign accept  = in_valid_i & in_ready_o;
  assign pos_inc = {1'b0, pos_q} + (LEN_W + 1)'(1);
  assign pos_new = (pos_inc > {1'b0, len_q}) ? LEN_W'(1) : pos_inc[LEN_W-1:0];
  assign slot    = pos_new - LEN_W'(1);

  assign wdata.x = {x_high_byte_i, x_low_byte_i};
  assign wdata.y = {y_high_byte_i, y_low_byte_i};
  assign wdata.z = {z_high_byte_i, z_low_byte_i};

  assign st_ctl.clear = cfg_we;
  assign st_ctl.we    = accept;
  assign st_ctl.re    = rd_en;

  afma_sample_store #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .waddr_i (slot[AW-1:0]),
    .raddr_i (cnt_q[AW-1:0]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // divisor 255 * len
  assign dvs     = (DVS_W'(len_q) << afma_pkg::BYTE_W) - DVS_W'(len_q);
  assign sum_sel = sum_q[axis_q];
  assign mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  afma_divider #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .mag_i  (mag),
    .dvs_i  (dvs),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign in_ready_o = (state_q == afma_pkg::ST_IDLE);

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    rd_vld_d      = rd_vld_q;
    axis_d        = axis_q;
    div_run_d     = div_run_q;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.neg   = sum_sel[SUM_W-1];
    case (state_q)
      afma_pkg::ST_IDLE: begin
        if (accept) begin
          pos_d    = pos_new;
          cnt_d    = '0;
          rd_vld_d = 1'b0;
          state_d  = afma_pkg::ST_SUM;
        end
      end
      afma_pkg::ST_SUM: begin
        if (cnt_q < len_q) begin
          rd_en    = 1'b1;
          cnt_d    = cnt_q + LEN_W'(1);
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
          if (!rd_vld_q) begin
            axis_d    = afma_pkg::AXIS_X;
            div_run_d = 1'b0;
            state_d   = afma_pkg::ST_DIV;
          end
        end
      end
      afma_pkg::ST_DIV: begin
        if (!div_run_q) begin
          div_ctl.start = 1'b1;
          div_run_d     = 1'b1;
        end else if (div_done) begin
          div_run_d = 1'b0;
          if (axis_q == afma_pkg::AXIS_Z) begin
            state_d = afma_pkg::ST_DONE;
          end else begin
            axis_d = axis_q + afma_pkg::AXIS_W'(1);
          end
        end
      end
      afma_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = afma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = afma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afma_pkg::ST_IDLE;
      len_q       <= LEN_W'(1);
      pos_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      axis_q      <= afma_pkg::AXIS_X;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      axis_q      <= axis_d;
      div_run_q   <= div_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q <= device_id_byte_i;
      for (int a = 0; a < afma_pkg::AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else if (rd_vld_q) begin
      sum_q[afma_pkg::AXIS_X] <= sum_q[afma_pkg::AXIS_X]
        + {{(SUM_W-afma_pkg::SAMPLE_W){rdata.x[afma_pkg::SAMPLE_W-1]}}, rdata.x};
      sum_q[afma_pkg::AXIS_Y] <= sum_q[afma_pkg::AXIS_Y]
        + {{(SUM_W-afma_pkg::SAMPLE_W){rdata.y[afma_pkg::SAMPLE_W-1]}}, rdata.y};
      sum_q[afma_pkg::AXIS_Z] <= sum_q[afma_pkg::AXIS_Z]
        + {{(SUM_W-afma_pkg::SAMPLE_W){rdata.z[afma_pkg::SAMPLE_W-1]}}, rdata.z};
    end
    if (div_done) begin
      res_q[axis_q] <= quot;
    end
    if (load_out) begin
      device_id_o <= id_q;
      x_average_o <= res_q[afma_pkg::AXIS_X];
      y_average_o <= res_q[afma_pkg::AXIS_Y];
      z_average_o <= res_q[afma_pkg::AXIS_Z];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
